### rtl/bsh_pkg.sv
package bsh_pkg;

    localparam int STRAIN_WIDTH_DEF = 32;
    localparam int STRESS_WIDTH_DEF = 48;
    localparam int CFG_INDEX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH   = 40;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ELASTIC_MODULUS = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_YIELD_STRESS    = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HARDENING_RATIO = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REFERENCE_RATIO = 8'd3;

    localparam logic [23:0] E0_RESET    = 24'd3200000;
    localparam logic [39:0] FY_RESET    = 40'd22609920;
    localparam logic [15:0] ALPHA_RESET = 16'd655;
    localparam logic [17:0] BETA_RESET  = 18'd32768;

    // branch codes
    localparam logic [2:0] BR_ELASTIC     = 3'd0;
    localparam logic [2:0] BR_YIELD_POS   = 3'd1;
    localparam logic [2:0] BR_UNLOAD_POS  = 3'd2;
    localparam logic [2:0] BR_RECOVER_POS = 3'd3;
    localparam logic [2:0] BR_YIELD_NEG   = 3'd4;
    localparam logic [2:0] BR_UNLOAD_NEG  = 3'd5;
    localparam logic [2:0] BR_RECOVER_NEG = 3'd6;

    // product scaling of the multiplier
    localparam logic [1:0] SH_HARDENING = 2'd0;  // >> 4
    localparam logic [1:0] SH_REFERENCE = 2'd1;  // >> 16
    localparam logic [1:0] SH_MODULUS   = 2'd2;  // >> 18
    localparam logic [1:0] SH_TANGENT   = 2'd3;  // >> 30

    // saturation width of a quotient
    localparam logic [1:0] SAT_STRAIN   = 2'd0;
    localparam logic [1:0] SAT_OFFSET   = 2'd1;
    localparam logic [1:0] SAT_STRESS   = 2'd2;

    typedef struct packed {
        logic       start;
        logic       neg;
        logic [1:0] shift_sel;
    } mul_ctl_t;

    typedef struct packed {
        logic       start;
        logic       neg;
        logic [1:0] sat_sel;
    } div_ctl_t;

endpackage

### rtl/bsh_if.sv
interface bsh_in_if #(parameter int STRAIN_WIDTH = bsh_pkg::STRAIN_WIDTH_DEF);
    logic                           valid;
    logic                           ready;
    logic signed [STRAIN_WIDTH-1:0] trial_strain;
    logic                           commit;
    modport source (output valid, trial_strain, commit, input ready);
    modport sink   (input valid, trial_strain, commit, output ready);
endinterface

interface bsh_out_if #(parameter int STRESS_WIDTH = bsh_pkg::STRESS_WIDTH_DEF);
    logic                           valid;
    logic                           ready;
    logic signed [STRESS_WIDTH-1:0] stress;
    logic signed [STRESS_WIDTH-1:0] tangent;
    logic [2:0]                     branch;
    modport source (output valid, stress, tangent, branch, input ready);
    modport sink   (input valid, stress, tangent, branch, output ready);
endinterface

interface bsh_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bsh_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [bsh_pkg::CFG_DATA_WIDTH-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bsh_mul.sv
module bsh_mul #(
    parameter int AW = 48,
    parameter int BW = 33,
    parameter int TW = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsh_pkg::mul_ctl_t    ctl,
    input  logic [AW-1:0]        a_mag,
    input  logic [BW-1:0]        b_mag,
    output logic                 done,
    output logic signed [TW-1:0] res
);

    localparam int PW = AW + BW;
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIN  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [PW-1:0]        acc_reg, acc_next;
    logic [PW-1:0]        a_reg, a_next;
    logic [BW-1:0]        b_reg, b_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           sh_reg, sh_next;
    logic signed [TW-1:0] res_reg, res_next;

    logic [4:0]  shamt;
    logic [PW:0] rnd, mag, lim, msat;

    // round half away from zero, then saturate the magnitude
    always_comb
    begin
        case (sh_reg)
            bsh_pkg::SH_HARDENING: shamt = 5'd4;
            bsh_pkg::SH_REFERENCE: shamt = 5'd16;
            bsh_pkg::SH_MODULUS:   shamt = 5'd18;
            default:               shamt = 5'd30;
        endcase
        rnd  = {1'b0, acc_reg} + ((PW+1)'(1) << (shamt - 5'd1));
        mag  = rnd >> shamt;
        lim  = ((PW+1)'(1) << (TW-1)) - (PW+1)'(!neg_reg);
        msat = (mag > lim) ? lim : mag;
        res_next = neg_reg ? -$signed(msat[TW-1:0]) : $signed(msat[TW-1:0]);
    end

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        sh_next    = sh_reg;
        case (phase_reg)
            M_IDLE:
            begin
                if (ctl.start)
                begin
                    acc_next   = '0;
                    a_next     = PW'(a_mag);
                    b_next     = b_mag;
                    neg_next   = ctl.neg;
                    sh_next    = ctl.shift_sel;
                    phase_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (b_reg == '0)
                begin
                    phase_next = M_FIN;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end
            M_FIN:
            begin
                done_next  = 1'b1;
                phase_next = M_IDLE;
            end
            default:
            begin
                phase_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
        if (phase_reg == M_FIN)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### rtl/bsh_div.sv
module bsh_div #(
    parameter int NW = 78,
    parameter int DW = 33,
    parameter int OW = 48,
    parameter int SW = 32,
    parameter int TW = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsh_pkg::div_ctl_t    ctl,
    input  logic [NW-1:0]        num_mag,
    input  logic [DW-1:0]        den_mag,
    output logic                 done,
    output logic signed [OW-1:0] res
);

    localparam int CW = $clog2(NW + 1);
    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        q_reg, q_next;
    logic [DW-1:0]        r_reg, r_next;
    logic [DW-1:0]        d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic                 zero_reg, zero_next;
    logic [1:0]           sat_reg, sat_next;
    logic signed [OW-1:0] res_reg, res_next;

    logic [DW:0] r_sh;
    logic [NW:0] qr, lim, msat;
    logic [6:0]  wm1;

    always_comb
    begin
        r_sh = {r_reg, q_reg[NW-1]};
        case (sat_reg)
            bsh_pkg::SAT_STRAIN: wm1 = 7'(SW - 1);
            bsh_pkg::SAT_OFFSET: wm1 = 7'(SW);
            default:             wm1 = 7'(TW - 1);
        endcase
        qr   = {1'b0, q_reg} + (NW+1)'({r_reg, 1'b0} >= {1'b0, d_reg});
        lim  = ((NW+1)'(1) << wm1) - (NW+1)'(!neg_reg);
        msat = zero_reg ? '0 : ((qr > lim) ? lim : qr);
        res_next = neg_reg ? -$signed(msat[OW-1:0]) : $signed(msat[OW-1:0]);
    end

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        sat_next   = sat_reg;
        case (phase_reg)
            D_IDLE:
            begin
                if (ctl.start)
                begin
                    q_next     = num_mag;
                    r_next     = '0;
                    d_next     = den_mag;
                    neg_next   = ctl.neg;
                    zero_next  = (num_mag == '0);
                    sat_next   = ctl.sat_sel;
                    cnt_next   = CW'(NW);
                    phase_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (r_sh >= {1'b0, d_reg})
                begin
                    r_next = DW'(r_sh - {1'b0, d_reg});
                    q_next = {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_sh[DW-1:0];
                    q_next = {q_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    phase_next = D_FIN;
                end
            end
            D_FIN:
            begin
                done_next  = 1'b1;
                phase_next = D_IDLE;
            end
            default:
            begin
                phase_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
        if (phase_reg == D_FIN)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### rtl/bilinear_steel_hysteresis.sv
// Bilinear hysteretic steel with seven branches. Each transfer on sample carries a trial
// strain (signed Q1.30) and a commit flag; the block answers with one transfer on result:
// stress and tangent in 2^-16 MPa and the branch code (0 elastic, 1/2/3 yield, unload and
// recover on the positive side, 4/5/6 the same on the negative side). Only a committing
// item updates the stored history (last point, both peaks, unload point). One item at a
// time: sample.ready is low from acceptance until its result has been taken. Every
// multiply and divide runs on one shift-add multiplier (one multiplier bit per cycle,
// stops early on small operands) and one restoring divider (STRESS_WIDTH+30 quotient
// bits). Elastic, yield and unload items take one multiply; an item whose stored branch
// is an unload branch adds a divide; a recovery item takes up to three divides and a
// multiply. After reset and after every configuration write to one of the four
// registers the block derives yield strain, hardening modulus and reference stress
// (two multiplies and a divide) and restarts the history; it accepts neither items nor
// writes meanwhile. Indexes beyond the four registers are taken and dropped.
module bilinear_steel_hysteresis #(
    parameter int STRAIN_WIDTH = bsh_pkg::STRAIN_WIDTH_DEF,
    parameter int STRESS_WIDTH = bsh_pkg::STRESS_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bsh_in_if.sink    sample,
    bsh_out_if.source result,
    bsh_cfg_if.sink   cfg
);

    localparam int SW = STRAIN_WIDTH;
    localparam int TW = STRESS_WIDTH;
    localparam int AW = (TW > 40) ? TW : 40;
    localparam int BW = SW + 1;
    localparam int NW = TW + 30;
    localparam int DW = SW + 1;
    localparam int OW = (TW > SW + 1) ? TW : SW + 1;
    localparam int CW = TW + 40;

    localparam logic [TW-1:0] MAX_TW = {1'b0, {(TW-1){1'b1}}};
    localparam logic [TW-1:0] MIN_TW = {1'b1, {(TW-1){1'b0}}};
    localparam logic [SW-1:0] MAX_SW = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] MIN_SW = {1'b1, {(SW-1){1'b0}}};

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_D_E1     = 4'd1;
    localparam logic [3:0] S_D_SREF   = 4'd2;
    localparam logic [3:0] S_D_EPSY   = 4'd3;
    localparam logic [3:0] S_PICK     = 4'd4;
    localparam logic [3:0] S_TGT_PICK = 4'd5;
    localparam logic [3:0] S_EVAL_MUL = 4'd6;
    localparam logic [3:0] S_TGT      = 4'd7;
    localparam logic [3:0] S_TAN      = 4'd8;
    localparam logic [3:0] S_SIG      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    // saturating stress add and subtract
    function automatic logic signed [TW-1:0] sat_tw(input logic signed [TW:0] s);
        logic signed [TW-1:0] r;
        if (s[TW] != s[TW-1])
        begin
            r = s[TW] ? $signed(MIN_TW) : $signed(MAX_TW);
        end
        else
        begin
            r = s[TW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TW-1:0] sadd(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [TW:0] s;
        s = {a[TW-1], a} + {b[TW-1], b};
        return sat_tw(s);
    endfunction

    function automatic logic signed [TW-1:0] ssub(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [TW:0] s;
        s = {a[TW-1], a} - {b[TW-1], b};
        return sat_tw(s);
    endfunction

    function automatic logic [TW-1:0] clamp_u(input logic [CW-1:0] u);
        logic [TW-1:0] r;
        if (u > CW'(MAX_TW))
        begin
            r = MAX_TW;
        end
        else
        begin
            r = u[TW-1:0];
        end
        return r;
    endfunction

    // configuration and derived values
    logic [23:0] e0_reg;
    logic [39:0] fy_reg;
    logic [15:0] alpha_reg;
    logic [17:0] beta_reg;
    logic signed [TW-1:0] e0t_reg, e1_reg, fyd_reg, sref_reg;
    logic signed [SW-1:0] epsy_reg;
    logic signed [SW-1:0] epsy_val;

    // committed history
    logic signed [SW-1:0] last_strain_reg, pps_reg, pns_reg, ues_reg;
    logic signed [TW-1:0] last_stress_reg, ppsig_reg, pnsig_reg, uesig_reg;
    logic [2:0]           last_branch_reg;

    // item in flight
    logic [3:0]           state_reg, state_next;
    logic                 launched_reg, launched_next;
    logic signed [SW-1:0] eps_reg;
    logic                 commit_reg;
    logic [2:0]           nb_reg, nb_next;
    logic signed [SW-1:0] ue_reg, ue_next;
    logic signed [TW-1:0] us_reg, us_next;
    logic signed [SW-1:0] er_reg, er_next;
    logic signed [TW-1:0] tan_reg, tan_next, sig_reg, sig_next;
    logic                 finish;

    // shared units
    bsh_pkg::mul_ctl_t    mul_ctl;
    bsh_pkg::div_ctl_t    div_ctl;
    logic [AW-1:0]        mul_a;
    logic [BW-1:0]        mul_b;
    logic                 mul_done, div_done;
    logic signed [TW-1:0] mul_res;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic signed [OW-1:0] div_res;

    logic                 cfg_fire, in_fire, cfg_known;
    logic signed [SW:0]   deps, eps_m_epsy, eps_p_epsy, eps_m_er, mx, den_s;
    logic signed [SW+1:0] er_sum;
    logic signed [SW-1:0] er_val;
    logic signed [TW-1:0] sr, pk_stress, ds, tgt, tan_abs, base;
    logic signed [SW-1:0] pk_strain;
    logic [TW-1:0]        ds_mag;
    logic                 tgt_neg;

    assign cfg.ready    = (state_reg == S_IDLE);
    assign sample.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg_fire     = cfg.valid && cfg.ready;
    assign in_fire      = sample.valid && sample.ready;
    assign cfg_known    = (cfg.index == bsh_pkg::CFG_ELASTIC_MODULUS)
                       || (cfg.index == bsh_pkg::CFG_YIELD_STRESS)
                       || (cfg.index == bsh_pkg::CFG_HARDENING_RATIO)
                       || (cfg.index == bsh_pkg::CFG_REFERENCE_RATIO);

    // a zero modulus puts the yield strain at the largest strain, whatever fy is
    assign epsy_val = (e0_reg == '0) ? MAX_SW : div_res[SW-1:0];

    assign result.valid   = (state_reg == S_OUT);
    assign result.stress  = sig_reg;
    assign result.tangent = tan_reg;
    assign result.branch  = nb_reg;

    // strain and stress differences
    always_comb
    begin
        deps       = {eps_reg[SW-1], eps_reg} - {last_strain_reg[SW-1], last_strain_reg};
        eps_m_epsy = {eps_reg[SW-1], eps_reg} - {epsy_reg[SW-1], epsy_reg};
        eps_p_epsy = {eps_reg[SW-1], eps_reg} + {epsy_reg[SW-1], epsy_reg};
        eps_m_er   = {eps_reg[SW-1], eps_reg} - {er_reg[SW-1], er_reg};
        sr         = (nb_reg == bsh_pkg::BR_RECOVER_POS) ? -sref_reg : sref_reg;
        pk_stress  = (nb_reg == bsh_pkg::BR_RECOVER_POS) ? pnsig_reg : ppsig_reg;
        pk_strain  = (nb_reg == bsh_pkg::BR_RECOVER_POS) ? pns_reg : pps_reg;
        den_s      = {er_reg[SW-1], er_reg} - {pk_strain[SW-1], pk_strain};
        tan_abs    = tan_reg[TW-1] ? -tan_reg : tan_reg;
        // target stress of a recovery line: from the held branch while picking
        tgt_neg    = (state_reg == S_TGT_PICK) ? (last_branch_reg == bsh_pkg::BR_UNLOAD_POS)
                                               : (nb_reg == bsh_pkg::BR_RECOVER_POS);
        tgt        = tgt_neg ? -sref_reg : sref_reg;
        ds         = (state_reg == S_TAN) ? ssub(sr, pk_stress) : ssub(tgt, us_reg);
        ds_mag     = ds[TW-1] ? $unsigned(-ds) : $unsigned(ds);
        // strain where the elastic line through the unload point meets the target
        er_sum     = {{2{ue_reg[SW-1]}}, ue_reg} + {div_res[SW], div_res[SW:0]};
        if (er_sum > (SW+2)'($signed(MAX_SW)))
        begin
            er_val = MAX_SW;
        end
        else if (er_sum < (SW+2)'($signed(MIN_SW)))
        begin
            er_val = MIN_SW;
        end
        else
        begin
            er_val = er_sum[SW-1:0];
        end
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_ctl.start     = 1'b0;
        mul_ctl.neg       = 1'b0;
        mul_ctl.shift_sel = bsh_pkg::SH_TANGENT;
        mul_a             = '0;
        mul_b             = '0;
        mx                = '0;
        div_ctl.start     = 1'b0;
        div_ctl.neg       = 1'b0;
        div_ctl.sat_sel   = bsh_pkg::SAT_STRESS;
        div_num           = '0;
        div_den           = DW'(e0_reg);
        case (state_reg)
            S_D_E1:
            begin
                mul_ctl.start     = !launched_reg;
                mul_ctl.shift_sel = bsh_pkg::SH_HARDENING;
                mul_a             = AW'(e0_reg);
                mul_b             = BW'(alpha_reg);
            end
            S_D_SREF:
            begin
                mul_ctl.start     = !launched_reg;
                mul_ctl.shift_sel = bsh_pkg::SH_REFERENCE;
                mul_a             = AW'(fy_reg);
                mul_b             = BW'(beta_reg);
            end
            S_D_EPSY:
            begin
                div_ctl.start   = !launched_reg;
                div_ctl.sat_sel = bsh_pkg::SAT_STRAIN;
                div_num         = NW'(fy_reg) << 18;
            end
            S_TGT_PICK, S_TGT:
            begin
                div_ctl.start   = !launched_reg;
                div_ctl.neg     = ds[TW-1];
                div_ctl.sat_sel = bsh_pkg::SAT_OFFSET;
                div_num         = NW'(ds_mag) << 18;
            end
            S_TAN:
            begin
                div_ctl.start   = !launched_reg;
                div_ctl.neg     = ds[TW-1] ^ den_s[SW];
                div_ctl.sat_sel = bsh_pkg::SAT_STRESS;
                div_num         = NW'(ds_mag) << 30;
                div_den         = den_s[SW] ? $unsigned(-den_s) : $unsigned(den_s);
            end
            S_EVAL_MUL:
            begin
                case (nb_reg)
                    bsh_pkg::BR_YIELD_POS: mx = eps_m_epsy;
                    bsh_pkg::BR_YIELD_NEG: mx = eps_p_epsy;
                    bsh_pkg::BR_UNLOAD_POS, bsh_pkg::BR_UNLOAD_NEG: mx = deps;
                    default: mx = {eps_reg[SW-1], eps_reg};
                endcase
                mul_ctl.start = !launched_reg;
                mul_ctl.neg   = mx[SW];
                if (nb_reg == bsh_pkg::BR_YIELD_POS || nb_reg == bsh_pkg::BR_YIELD_NEG)
                begin
                    mul_ctl.shift_sel = bsh_pkg::SH_TANGENT;
                    mul_a             = AW'($unsigned(e1_reg));
                end
                else
                begin
                    mul_ctl.shift_sel = bsh_pkg::SH_MODULUS;
                    mul_a             = AW'(e0_reg);
                end
                mul_b = mx[SW] ? $unsigned(-mx) : $unsigned(mx);
            end
            S_SIG:
            begin
                mul_ctl.start     = !launched_reg;
                mul_ctl.neg       = eps_m_er[SW] ^ tan_reg[TW-1];
                mul_ctl.shift_sel = bsh_pkg::SH_TANGENT;
                mul_a             = AW'($unsigned(tan_abs));
                mul_b             = eps_m_er[SW] ? $unsigned(-eps_m_er) : $unsigned(eps_m_er);
            end
            default:
            begin
                mx = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        nb_next       = nb_reg;
        ue_next       = ue_reg;
        us_next       = us_reg;
        er_next       = er_reg;
        tan_next      = tan_reg;
        sig_next      = sig_reg;
        finish        = 1'b0;
        base          = '0;
        if (mul_ctl.start || div_ctl.start)
        begin
            launched_next = 1'b1;
        end
        if (mul_done || div_done)
        begin
            launched_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_known)
                    begin
                        state_next = S_D_E1;
                    end
                end
                else if (in_fire)
                begin
                    state_next = S_PICK;
                end
            end
            S_D_E1:
            begin
                if (mul_done)
                begin
                    state_next = S_D_SREF;
                end
            end
            S_D_SREF:
            begin
                if (mul_done)
                begin
                    state_next = S_D_EPSY;
                end
            end
            S_D_EPSY:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PICK:
            begin
                ue_next = ues_reg;
                us_next = uesig_reg;
                case (last_branch_reg)
                    bsh_pkg::BR_YIELD_POS:
                    begin
                        if (deps[SW])
                        begin
                            ue_next = last_strain_reg;
                            us_next = last_stress_reg;
                            nb_next = bsh_pkg::BR_UNLOAD_POS;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_YIELD_POS;
                        end
                    end
                    bsh_pkg::BR_UNLOAD_POS, bsh_pkg::BR_UNLOAD_NEG:
                    begin
                        nb_next = last_branch_reg;
                    end
                    bsh_pkg::BR_RECOVER_POS:
                    begin
                        if (!deps[SW] && deps != '0)
                        begin
                            ue_next = last_strain_reg;
                            us_next = last_stress_reg;
                            nb_next = bsh_pkg::BR_UNLOAD_NEG;
                        end
                        else if (eps_reg < pns_reg)
                        begin
                            nb_next = bsh_pkg::BR_YIELD_NEG;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_POS;
                        end
                    end
                    bsh_pkg::BR_YIELD_NEG:
                    begin
                        if (!deps[SW] && deps != '0)
                        begin
                            ue_next = last_strain_reg;
                            us_next = last_stress_reg;
                            nb_next = bsh_pkg::BR_UNLOAD_NEG;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_YIELD_NEG;
                        end
                    end
                    bsh_pkg::BR_RECOVER_NEG:
                    begin
                        if (deps[SW])
                        begin
                            ue_next = last_strain_reg;
                            us_next = last_stress_reg;
                            nb_next = bsh_pkg::BR_UNLOAD_POS;
                        end
                        else if (eps_reg > pps_reg)
                        begin
                            nb_next = bsh_pkg::BR_YIELD_POS;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_NEG;
                        end
                    end
                    default:
                    begin
                        if (!eps_m_epsy[SW] && eps_m_epsy != '0)
                        begin
                            nb_next = bsh_pkg::BR_YIELD_POS;
                        end
                        else if (eps_p_epsy[SW])
                        begin
                            nb_next = bsh_pkg::BR_YIELD_NEG;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_ELASTIC;
                        end
                    end
                endcase
                if (last_branch_reg == bsh_pkg::BR_UNLOAD_POS
                    || last_branch_reg == bsh_pkg::BR_UNLOAD_NEG)
                begin
                    state_next = S_TGT_PICK;
                end
                else if (nb_next == bsh_pkg::BR_RECOVER_POS
                         || nb_next == bsh_pkg::BR_RECOVER_NEG)
                begin
                    state_next = S_TGT;
                end
                else
                begin
                    state_next = S_EVAL_MUL;
                end
            end
            S_TGT_PICK:
            begin
                if (div_done)
                begin
                    er_next = er_val;
                    if (last_branch_reg == bsh_pkg::BR_UNLOAD_POS)
                    begin
                        if (eps_reg > pps_reg)
                        begin
                            nb_next = bsh_pkg::BR_YIELD_POS;
                        end
                        else if (eps_reg > ue_reg)
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_NEG;
                        end
                        else if (eps_reg < er_val)
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_POS;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_UNLOAD_POS;
                        end
                    end
                    else
                    begin
                        if (eps_reg < pns_reg)
                        begin
                            nb_next = bsh_pkg::BR_YIELD_NEG;
                        end
                        else if (eps_reg < ue_reg)
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_POS;
                        end
                        else if (eps_reg > er_val)
                        begin
                            nb_next = bsh_pkg::BR_RECOVER_NEG;
                        end
                        else
                        begin
                            nb_next = bsh_pkg::BR_UNLOAD_NEG;
                        end
                    end
                    // the target just found is reused when the recovery side matches
                    if ((last_branch_reg == bsh_pkg::BR_UNLOAD_POS
                         && nb_next == bsh_pkg::BR_RECOVER_POS)
                        || (last_branch_reg == bsh_pkg::BR_UNLOAD_NEG
                            && nb_next == bsh_pkg::BR_RECOVER_NEG))
                    begin
                        state_next = S_TAN;
                    end
                    else if (nb_next == bsh_pkg::BR_RECOVER_POS
                             || nb_next == bsh_pkg::BR_RECOVER_NEG)
                    begin
                        state_next = S_TGT;
                    end
                    else
                    begin
                        state_next = S_EVAL_MUL;
                    end
                end
            end
            S_TGT:
            begin
                if (div_done)
                begin
                    er_next    = er_val;
                    state_next = S_TAN;
                end
            end
            S_TAN:
            begin
                if (div_done)
                begin
                    tan_next   = div_res[TW-1:0];
                    state_next = S_SIG;
                end
            end
            S_SIG:
            begin
                if (mul_done)
                begin
                    sig_next   = sadd(sr, mul_res);
                    finish     = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_EVAL_MUL:
            begin
                case (nb_reg)
                    bsh_pkg::BR_YIELD_POS: base = fyd_reg;
                    bsh_pkg::BR_YIELD_NEG: base = -fyd_reg;
                    bsh_pkg::BR_UNLOAD_POS, bsh_pkg::BR_UNLOAD_NEG: base = last_stress_reg;
                    default: base = '0;
                endcase
                if (mul_done)
                begin
                    sig_next = sadd(base, mul_res);
                    if (nb_reg == bsh_pkg::BR_YIELD_POS || nb_reg == bsh_pkg::BR_YIELD_NEG)
                    begin
                        tan_next = e1_reg;
                    end
                    else
                    begin
                        tan_next = e0t_reg;
                    end
                    finish     = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_D_E1;
            launched_reg <= 1'b0;
            e0_reg       <= bsh_pkg::E0_RESET;
            fy_reg       <= bsh_pkg::FY_RESET;
            alpha_reg    <= bsh_pkg::ALPHA_RESET;
            beta_reg     <= bsh_pkg::BETA_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (cfg_fire)
            begin
                case (cfg.index)
                    bsh_pkg::CFG_ELASTIC_MODULUS: e0_reg    <= cfg.data[23:0];
                    bsh_pkg::CFG_YIELD_STRESS:    fy_reg    <= cfg.data[39:0];
                    bsh_pkg::CFG_HARDENING_RATIO: alpha_reg <= cfg.data[15:0];
                    bsh_pkg::CFG_REFERENCE_RATIO: beta_reg  <= cfg.data[17:0];
                    default:                      e0_reg    <= e0_reg;
                endcase
            end
        end
    end

    // derived values, history and item data: written before they are read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            eps_reg    <= sample.trial_strain;
            commit_reg <= sample.commit;
        end
        nb_reg  <= nb_next;
        ue_reg  <= ue_next;
        us_reg  <= us_next;
        er_reg  <= er_next;
        tan_reg <= tan_next;
        sig_reg <= sig_next;
        if (state_reg == S_D_E1 && mul_done)
        begin
            e1_reg <= mul_res;
        end
        if (state_reg == S_D_SREF && mul_done)
        begin
            sref_reg <= mul_res;
        end
        if (state_reg == S_D_EPSY && div_done)
        begin
            // restart the history under the new registers
            epsy_reg        <= epsy_val;
            e0t_reg         <= clamp_u(CW'(e0_reg) << 12);
            fyd_reg         <= clamp_u(CW'(fy_reg));
            last_strain_reg <= '0;
            last_stress_reg <= '0;
            last_branch_reg <= bsh_pkg::BR_ELASTIC;
            pps_reg         <= epsy_val;
            ppsig_reg       <= clamp_u(CW'(fy_reg));
            pns_reg         <= -epsy_val;
            pnsig_reg       <= -clamp_u(CW'(fy_reg));
            ues_reg         <= '0;
            uesig_reg       <= '0;
        end
        if (finish && commit_reg)
        begin
            last_strain_reg <= eps_reg;
            last_stress_reg <= sig_next;
            last_branch_reg <= nb_reg;
            ues_reg         <= ue_reg;
            uesig_reg       <= us_reg;
            if (nb_reg == bsh_pkg::BR_YIELD_POS && eps_reg > pps_reg)
            begin
                pps_reg   <= eps_reg;
                ppsig_reg <= sig_next;
            end
            if (nb_reg == bsh_pkg::BR_YIELD_NEG && eps_reg < pns_reg)
            begin
                pns_reg   <= eps_reg;
                pnsig_reg <= sig_next;
            end
        end
    end

    bsh_mul #(
        .AW (AW),
        .BW (BW),
        .TW (TW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    bsh_div #(
        .NW (NW),
        .DW (DW),
        .OW (OW),
        .SW (SW),
        .TW (TW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .num_mag (div_num),
        .den_mag (div_den),
        .done    (div_done),
        .res     (div_res)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_ctl.start && div_ctl.start))
        else $error("multiplier and divider started together");

    a_item_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == S_PICK))
        else $error("accepted item did not enter branch selection");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !sample.ready)
        else $error("new item accepted while a result is pending");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready) |=> !result.valid)
        else $error("result repeated after transfer");

    a_branch_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (nb_reg <= bsh_pkg::BR_RECOVER_NEG))
        else $error("invalid branch code on result");

endmodule
